>>> hdl/pald_pkg.sv
// ----------------------------------------------------------------------------
// pald_pkg
// Shared types and constants for the point-along-line block.
// ----------------------------------------------------------------------------
package pald_pkg;

  localparam int COORD_W       = 32;
  localparam int DIFF_W        = 33;  // end - start, signed
  localparam int ABS_W         = 33;  // |end - start|
  localparam int SQ_W          = 66;  // sum of three squares
  localparam int PROD_W        = 64;  // |dist| * |D_i|
  localparam int QUO_W         = 32;  // offset quotient bits
  localparam int QDEPTH        = 4;   // front-to-back queue depth
  localparam int FRAC_BITS_DEF = 16;
  localparam int LANES         = 3;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  // One classified item handed from the front end to the back end
  typedef struct packed {
    logic [LANES-1:0][COORD_W-1:0] start;
    logic [LANES-1:0][PROD_W-1:0]  prod;
    logic [LANES-1:0]              neg;
    logic                          degen;
    logic [SQ_W-1:0]               sumsq;
  } pald_item_t;

endpackage

>>> hdl/point_at_distance_on_line_3d.sv
// ----------------------------------------------------------------------------
// point_at_distance_on_line_3d
// Point at a signed distance from start along the line start -> end, Q16.16.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one beat per input beat, in order.
// Three front stages form D = end - start, |D|^2 and |dist|*|D_i|; a 4-entry
// queue decouples the front from the back; the back runs a one-bit-per-stage
// square root of |D|^2 * 2^(2*FRAC_BITS), then a one-bit-per-stage divide in
// three lanes, then rounding (ties away from zero), the add to start and
// 32-bit saturation into the output register. Throughput is one beat per
// cycle while m_tready stays high. A zero-length line returns start with
// degenerate set; a clipped coordinate sets saturated.
// ----------------------------------------------------------------------------
module point_at_distance_on_line_3d #(
  parameter int FRAC_BITS = pald_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, dist_req (32b each)
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y, point_z (32b each)
  output logic [95:0]  m_tdata,
  // degenerate, saturated
  output logic [1:0]   m_tuser
);
  import pald_pkg::*;

  localparam int RW = ABS_W + FRAC_BITS;

  logic [LANES-1:0][COORD_W-1:0] in_start, in_end;

  // front -> queue
  logic       f_valid, f_ready;
  pald_item_t f_item;

  // queue -> back
  logic       q_valid;
  logic [$bits(pald_item_t)-1:0] q_data;

  // back enable: the whole back pipeline moves while the output can take
  logic       be;

  logic       r_valid;
  pald_item_t r_item;
  logic [RW-1:0] r_root;

  logic       d_valid;
  pald_item_t d_item;
  logic [RW-1:0] d_len;
  logic [LANES-1:0][QUO_W-1:0] d_quo;
  logic [LANES-1:0][RW:0]      d_rem;

  logic [LANES-1:0][COORD_W-1:0] pt;
  logic [LANES-1:0]              clip;

  assign in_start[0] = s_tdata[31:0];
  assign in_start[1] = s_tdata[63:32];
  assign in_start[2] = s_tdata[95:64];
  assign in_end[0]   = s_tdata[127:96];
  assign in_end[1]   = s_tdata[159:128];
  assign in_end[2]   = s_tdata[191:160];

  pald_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_start  (in_start),
    .in_end    (in_end),
    .in_dist   (s_tdata[223:192]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  pald_fifo #(
    .WIDTH ($bits(pald_item_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_item),
    .out_valid (q_valid),
    .out_ready (be),
    .out_data  (q_data)
  );

  assign be = !m_tvalid || m_tready;

  pald_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (be),
    .in_valid  (q_valid),
    .in_item   (pald_item_t'(q_data)),
    .out_valid (r_valid),
    .out_item  (r_item),
    .out_root  (r_root)
  );

  pald_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (be),
    .in_valid  (r_valid),
    .in_item   (r_item),
    .in_len    (r_root),
    .out_valid (d_valid),
    .out_item  (d_item),
    .out_len   (d_len),
    .out_quo   (d_quo),
    .out_rem   (d_rem)
  );

  // round half away from zero on the magnitude, apply sign, add, clip
  always_comb begin
    logic [QUO_W:0]     mag;
    logic [COORD_W+1:0] s34, p34;
    for (int l = 0; l < LANES; l++) begin
      mag = {1'b0, d_quo[l]} + (QUO_W+1)'({d_rem[l], 1'b0} >= {2'b00, d_len});
      s34 = {{2{d_item.start[l][COORD_W-1]}}, d_item.start[l]};
      p34 = d_item.neg[l] ? s34 - {1'b0, mag} : s34 + {1'b0, mag};
      if (d_item.degen) begin
        pt[l]   = d_item.start[l];
        clip[l] = 1'b0;
      end else if (p34[COORD_W+1:COORD_W-1] == 3'b000
                   || p34[COORD_W+1:COORD_W-1] == 3'b111) begin
        pt[l]   = p34[COORD_W-1:0];
        clip[l] = 1'b0;
      end else begin
        pt[l]   = p34[COORD_W+1] ? COORD_MIN : COORD_MAX;
        clip[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (be) m_tvalid <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      m_tdata <= {pt[2], pt[1], pt[0]};
      m_tuser <= {|clip, d_item.degen};
    end
  end

endmodule

>>> hdl/pald_front.sv
// ----------------------------------------------------------------------------
// pald_front
// Front end: takes a beat, forms the direction, its squared length and the
// distance products, and flags a zero-length line.
// ----------------------------------------------------------------------------
module pald_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pald_pkg::LANES-1:0][pald_pkg::COORD_W-1:0] in_start,
  input  logic [pald_pkg::LANES-1:0][pald_pkg::COORD_W-1:0] in_end,
  input  logic [pald_pkg::COORD_W-1:0]            in_dist,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output pald_pkg::pald_item_t                    out_item
);
  import pald_pkg::*;

  logic en;
  logic v1, v2, v3;

  // stage 1: differences
  logic [LANES-1:0][COORD_W-1:0] st1;
  logic [LANES-1:0][ABS_W-1:0]   absd1;
  logic [LANES-1:0]              neg1;
  logic                          degen1;
  logic [COORD_W-1:0]            dmag1;

  // stage 2: squares and products
  logic [LANES-1:0][COORD_W-1:0] st2;
  logic [LANES-1:0][SQ_W-1:0]    sq2;
  logic [LANES-1:0][PROD_W-1:0]  prod2;
  logic [LANES-1:0]              neg2;
  logic                          degen2;

  logic [LANES-1:0][DIFF_W-1:0]  diff;
  logic [LANES-1:0][ABS_W-1:0]   absd;
  logic [COORD_W-1:0]            dmag;

  assign en       = !v3 || out_ready;
  assign in_ready = en;
  assign out_valid = v3;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {in_end[i][COORD_W-1], in_end[i]} - {in_start[i][COORD_W-1], in_start[i]};
      absd[i] = diff[i][DIFF_W-1] ? ABS_W'(-diff[i]) : ABS_W'(diff[i]);
    end
    dmag = in_dist[COORD_W-1] ? -in_dist : in_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        st1[i]   <= in_start[i];
        absd1[i] <= absd[i];
        neg1[i]  <= in_dist[COORD_W-1] ^ diff[i][DIFF_W-1];
      end
      degen1 <= (diff == '0);
      dmag1  <= dmag;

      for (int i = 0; i < LANES; i++) begin
        st2[i]   <= st1[i];
        sq2[i]   <= SQ_W'(absd1[i]) * SQ_W'(absd1[i]);
        prod2[i] <= PROD_W'(dmag1) * PROD_W'(absd1[i]);
        neg2[i]  <= neg1[i];
      end
      degen2 <= degen1;

      out_item.start <= st2;
      out_item.prod  <= prod2;
      out_item.neg   <= neg2;
      out_item.degen <= degen2;
      out_item.sumsq <= sq2[0] + sq2[1] + sq2[2];
    end
  end

endmodule

>>> hdl/pald_fifo.sv
// ----------------------------------------------------------------------------
// pald_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pald_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

>>> hdl/pald_sqrt.sv
// ----------------------------------------------------------------------------
// pald_sqrt
// Pipelined digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pald_sqrt #(
  parameter int FRAC_BITS = pald_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  pald_pkg::pald_item_t  in_item,
  output logic                  out_valid,
  output pald_pkg::pald_item_t  out_item,
  output logic [pald_pkg::ABS_W+FRAC_BITS-1:0] out_root
);
  import pald_pkg::*;

  localparam int RW  = ABS_W + FRAC_BITS;  // root bits
  localparam int QPR = SQ_W / 2;           // radicand pairs that come from sumsq

  logic                 vld  [RW+1];
  pald_item_t           item [RW+1];
  logic [RW-1:0]        root [RW+1];
  logic [RW+1:0]        rem  [RW+1];

  assign vld[0]  = in_valid;
  assign item[0] = in_item;
  assign root[0] = '0;
  assign rem[0]  = '0;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [1:0]    pair;
    logic [RW+1:0] sh, trial;
    logic          ge;

    if (i < QPR) begin : g_pair
      assign pair = item[i].sumsq[SQ_W-1-2*i -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign sh    = {rem[i][RW-1:0], pair};
    assign trial = {root[i], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item[i+1] <= item[i];
        root[i+1] <= {root[i][RW-2:0], ge};
        rem[i+1]  <= ge ? sh - trial : sh;
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_item  = item[RW];
  assign out_root  = root[RW];

endmodule

>>> hdl/pald_div.sv
// ----------------------------------------------------------------------------
// pald_div
// Pipelined restoring divide of the three scaled products by the length,
// one quotient bit per stage for all lanes.
// ----------------------------------------------------------------------------
module pald_div #(
  parameter int FRAC_BITS = pald_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  pald_pkg::pald_item_t                   in_item,
  input  logic [pald_pkg::ABS_W+FRAC_BITS-1:0]   in_len,
  output logic                                   out_valid,
  output pald_pkg::pald_item_t                   out_item,
  output logic [pald_pkg::ABS_W+FRAC_BITS-1:0]   out_len,
  output logic [pald_pkg::LANES-1:0][pald_pkg::QUO_W-1:0]             out_quo,
  output logic [pald_pkg::LANES-1:0][pald_pkg::ABS_W+FRAC_BITS:0]     out_rem
);
  import pald_pkg::*;

  localparam int RW = ABS_W + FRAC_BITS;

  logic                            vld  [QUO_W+1];
  pald_item_t                      item [QUO_W+1];
  logic [RW-1:0]                   len  [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0]     quo  [QUO_W+1];
  logic [LANES-1:0][RW:0]          rem  [QUO_W+1];

  assign vld[0]  = in_valid;
  assign item[0] = in_item;
  assign len[0]  = in_len;
  assign quo[0]  = '0;

  // numerator is prod << FRAC_BITS; its bits above the quotient field seed
  // the remainder, which stays below the length
  for (genvar l = 0; l < LANES; l++) begin : g_seed
    assign rem[0][l] = {2'b00, in_item.prod[l][PROD_W-1 : QUO_W-FRAC_BITS]};
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int NB = QUO_W - 1 - k;  // numerator bit shifted in
    logic [LANES-1:0][RW:0]      sh;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0]            nbit;
    logic [LANES-1:0][RW:0]      rem_n;
    logic [LANES-1:0][QUO_W-1:0] quo_n;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (NB >= FRAC_BITS) begin : g_bit
        assign nbit[l] = item[k].prod[l][NB-FRAC_BITS];
      end else begin : g_zero
        assign nbit[l] = 1'b0;
      end
      assign sh[l]    = {rem[k][l][RW-1:0], nbit[l]};
      assign ge[l]    = (sh[l] >= {1'b0, len[k]});
      assign rem_n[l] = ge[l] ? sh[l] - {1'b0, len[k]} : sh[l];
      assign quo_n[l] = {quo[k][l][QUO_W-2:0], ge[l]};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item[k+1] <= item[k];
        len[k+1]  <= len[k];
        quo[k+1]  <= quo_n;
        rem[k+1]  <= rem_n;
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_item  = item[QUO_W];
  assign out_len   = len[QUO_W];
  assign out_quo   = quo[QUO_W];
  assign out_rem   = rem[QUO_W];

endmodule

>>> hdl/pald_checker.sv
// ----------------------------------------------------------------------------
// pald_checker
// Port-level checks for the point-along-line block, bound to the top level.
// ----------------------------------------------------------------------------
module pald_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // a stalled beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("stalled output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // a zero-length line returns start, which can never clip
  a_degen_no_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("degenerate beat marked saturated");

endmodule

bind point_at_distance_on_line_3d pald_checker u_chk (.*);

>>> sim/pald_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pald_scoreboard
// Watches both streams, predicts each output beat from the input beat and
// compares field by field, in order.
// ----------------------------------------------------------------------------
module pald_scoreboard #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [223:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [95:0] pt;
    logic [1:0]  flags;  // degenerate, saturated
  } point_t;

  point_t expected_points[$];

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic point_t predict_point(logic [223:0] d);
    logic signed [63:0] s [3];
    logic signed [63:0] dv [3];
    logic signed [63:0] dreq;
    logic signed [63:0] p;
    logic [63:0]  dmag;
    logic [63:0]  a;
    logic [127:0] q;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  lf;
    logic [63:0]  mag;
    logic         sat;
    logic         degen;
    point_t       r;
    q = '0;
    sat = 1'b0;
    dreq = $signed(d[223:192]);
    dmag = dreq < 0 ? -dreq : dreq;
    for (int i = 0; i < 3; i++) begin
      s[i] = $signed(d[32*i +: 32]);
      dv[i] = $signed(d[32*(i+3) +: 32]) - s[i];
      a = dv[i] < 0 ? -dv[i] : dv[i];
      q += {64'd0, a} * {64'd0, a};
    end
    degen = (q == 0);
    lf = degen ? 64'd0 : isqrt(q << (2 * FRAC_BITS));
    for (int i = 0; i < 3; i++) begin
      p = s[i];
      if (!degen) begin
        a = dv[i] < 0 ? -dv[i] : dv[i];
        num = ({64'd0, dmag} * {64'd0, a}) << FRAC_BITS;
        quo = num / lf;
        rem = num % lf;
        if (rem >= lf - rem) quo++;
        // offsets clamp well past the coordinate range
        mag = (quo > (128'd1 << 40)) ? (64'd1 << 40) : quo[63:0];
        p += ((dreq < 0) != (dv[i] < 0)) ? -$signed(mag) : $signed(mag);
      end
      if (p > 64'sd2147483647) begin
        p = 64'sd2147483647; sat = 1'b1;
      end
      if (p < -64'sd2147483648) begin
        p = -64'sd2147483648; sat = 1'b1;
      end
      r.pt[32*i +: 32] = p[31:0];
    end
    r.flags = {sat, degen};
    return r;
  endfunction

  task automatic report(string what, logic [95:0] got, logic [95:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) expected_points.push_back(predict_point(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          report("unexpected beat", m_tdata, '0);
        end else begin
          e = expected_points.pop_front();
          for (int i = 0; i < 3; i++)
            if (m_tdata[32*i +: 32] !== e.pt[32*i +: 32])
              report($sformatf("point[%0d]", i), 96'(m_tdata[32*i +: 32]),
                     96'(e.pt[32*i +: 32]));
          if (m_tuser[0] !== e.flags[0])
            report("degenerate", 96'(m_tuser[0]), 96'(e.flags[0]));
          if (m_tuser[1] !== e.flags[1])
            report("saturated", 96'(m_tuser[1]), 96'(e.flags[1]));
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams directed and random line/distance beats into the block, idles both
// sides at random, holds the output off once to fill the pipe, and reports.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_RANDOM = 900;
  localparam int LIMIT    = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  logic         no_idle = 1'b0;    // calm stretch: neither side idles
  logic         hold_off = 1'b0;   // long output stall
  logic [223:0] directed [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_at_distance_on_line_3d uut (.*);

  pald_scoreboard chk (.*);

  // corner coordinates and distances
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 255) << 16;
      4: return -($urandom_range(0, 255) << 16);
      5: return $urandom_range(0, 32'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [223:0] random_beat();
    logic [223:0] d;
    for (int i = 0; i < 7; i++) d[32*i +: 32] = pick_coord();
    // some zero-length lines
    if ($urandom_range(0, 19) == 0) d[191:96] = d[95:0];
    return d;
  endfunction

  // receiver: random ready, long hold-off when requested
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(logic [223:0] d);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 37) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    directed.push_back({32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 96'h0});
    directed.push_back({32'hFFFF_0000, 96'h0, 96'h0});                  // degenerate
    directed.push_back({32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000, 96'h0});
    directed.push_back({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                        32'h7FFF_FFFF});                                   // returns the origin
    directed.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    directed.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    directed.push_back({32'hFFFE_0000, 32'h0003_0000, 32'h0004_0000, 32'h0,
                        32'h0, 32'h0, 32'h0});                             // negative distance
    directed.push_back({32'h0, 32'h0, 32'h0, 32'h1, 32'h5, 32'h5, 32'h5});
    directed.push_back({32'hFFFF_FFFF, 96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 96'h0});
    directed.push_back({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
                        32'h7FFF_FFFF});
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) no_idle <= 1'b1;
      if (n == 350) no_idle <= 1'b0;
      if (n == 500) begin
        // stall the output long enough for the block to back up
        hold_off <= 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      send(random_beat());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
